// ===== rtl/ffba_pkg.sv =====
// Shared types, codes and constants for the first-fit block allocator.
package ffba_pkg;

   localparam int unsigned ALLOC_DEPTH_DEF = 1024;
   localparam int unsigned FREE_DEPTH_DEF  = 1024;
   localparam int unsigned MAX_BLOCK       = 124;
   localparam int unsigned TAG_BITS        = 16;
   localparam int unsigned SIZE_BITS       = 7;
   localparam int unsigned POS_BITS        = 10;
   localparam int unsigned COUNT_BITS      = 11;
   localparam int unsigned ENTRY_BITS      = SIZE_BITS + TAG_BITS;

   localparam logic [1:0] OP_PLACE   = 2'd0;
   localparam logic [1:0] OP_ALLOC   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] ST_GROWN    = 3'd0;
   localparam logic [2:0] ST_SPLIT    = 3'd1;
   localparam logic [2:0] ST_EXACT    = 3'd2;
   localparam logic [2:0] ST_RELEASED = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_BAD_POS  = 3'd5;

   typedef struct packed {
      logic [1:0]            operation;
      logic [SIZE_BITS-1:0]  request_size;
      logic [POS_BITS-1:0]   position;
      logic [TAG_BITS-1:0]   tag;
   } req_item_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [POS_BITS-1:0]   free_index;
      logic [SIZE_BITS-1:0]  released_size;
      logic [TAG_BITS-1:0]   released_tag;
      logic [31:0]           total_allocated;
      logic [COUNT_BITS-1:0] allocated_count;
      logic [COUNT_BITS-1:0] free_count;
   } rsp_item_type;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_set_pos;
      logic       idx_inc;
      logic       f_rd;
      logic       f_rd_next;
      logic       f_wr_shift;
      logic       f_wr_split;
      logic       f_push;
      logic       f_len_dec;
      logic       a_rd;
      logic       a_rd_next;
      logic       a_wr_shift;
      logic       a_capture;
      logic       a_push;
      logic       a_len_dec;
      logic       grow;
      logic       fidx_set;
      logic       status_we;
      logic [2:0] status_val;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       a_full;
      logic       f_full;
      logic       pos_bad;
      logic       scan_end;
      logic       f_last;
      logic       a_last;
      logic       fit;
      logic       bigger;
      logic       out_busy;
   } stat_type;

endpackage

// ===== rtl/ffba_ctrl.sv =====
// Sequencing state machine of the first-fit block allocator.
module ffba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffba_pkg::stat_type stat,
   output ffba_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      IDLE, DECIDE, SRCH_RD, SRCH_CHK, FSH_RD, FSH_WR,
      AGET_RD, AGET_CAP, ASH_RD, ASH_WR, FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            state_in = FINISH;
            unique case (stat.op)
               ffba_pkg::OP_PLACE: begin
                  cmd.status_we = 1'b1;
                  if (stat.a_full) begin
                     cmd.status_val = ffba_pkg::ST_FULL;
                  end else begin
                     cmd.status_val = ffba_pkg::ST_GROWN;
                     cmd.a_push     = 1'b1;
                     cmd.grow       = 1'b1;
                  end
               end
               ffba_pkg::OP_ALLOC: begin
                  if (stat.a_full) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = ffba_pkg::ST_FULL;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = SRCH_RD;
                  end
               end
               ffba_pkg::OP_RELEASE: begin
                  if (stat.pos_bad) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = ffba_pkg::ST_BAD_POS;
                  end else if (stat.f_full) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = ffba_pkg::ST_FULL;
                  end else begin
                     cmd.idx_set_pos = 1'b1;
                     state_in        = AGET_RD;
                  end
               end
               default: begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = ffba_pkg::ST_BAD_POS;
               end
            endcase
         end
         SRCH_RD: begin
            if (stat.scan_end) begin
               cmd.a_push     = 1'b1;
               cmd.grow       = 1'b1;
               cmd.status_we  = 1'b1;
               cmd.status_val = ffba_pkg::ST_GROWN;
               state_in       = FINISH;
            end else begin
               cmd.f_rd = 1'b1;
               state_in = SRCH_CHK;
            end
         end
         SRCH_CHK: begin
            if (stat.fit) begin
               cmd.fidx_set  = 1'b1;
               cmd.a_push    = 1'b1;
               cmd.status_we = 1'b1;
               if (stat.bigger) begin
                  cmd.f_wr_split = 1'b1;
                  cmd.status_val = ffba_pkg::ST_SPLIT;
                  state_in       = FINISH;
               end else begin
                  cmd.status_val = ffba_pkg::ST_EXACT;
                  state_in       = FSH_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = SRCH_RD;
            end
         end
         FSH_RD: begin
            if (stat.f_last) begin
               cmd.f_len_dec = 1'b1;
               state_in      = FINISH;
            end else begin
               cmd.f_rd_next = 1'b1;
               state_in      = FSH_WR;
            end
         end
         FSH_WR: begin
            cmd.f_wr_shift = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = FSH_RD;
         end
         AGET_RD: begin
            cmd.a_rd = 1'b1;
            state_in = AGET_CAP;
         end
         AGET_CAP: begin
            cmd.a_capture  = 1'b1;
            cmd.status_we  = 1'b1;
            cmd.status_val = ffba_pkg::ST_RELEASED;
            state_in       = ASH_RD;
         end
         ASH_RD: begin
            if (stat.a_last) begin
               cmd.a_len_dec = 1'b1;
               cmd.f_push    = 1'b1;
               state_in      = FINISH;
            end else begin
               cmd.a_rd_next = 1'b1;
               state_in      = ASH_WR;
            end
         end
         ASH_WR: begin
            cmd.a_wr_shift = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = ASH_RD;
         end
         FINISH: begin
            if (!stat.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

endmodule

// ===== rtl/ffba_dp.sv =====
// Datapath of the first-fit block allocator: lists, lengths, total and result register.
module ffba_dp #(
   parameter int unsigned ALLOC_DEPTH = ffba_pkg::ALLOC_DEPTH_DEF,
   parameter int unsigned FREE_DEPTH  = ffba_pkg::FREE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffba_pkg::req_item_type req_data,
   input  ffba_pkg::cmd_type      cmd,
   output ffba_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffba_pkg::rsp_item_type rsp_data
);

   localparam int unsigned AW  = $clog2(ALLOC_DEPTH);
   localparam int unsigned FW  = $clog2(FREE_DEPTH);
   localparam int unsigned ALW = $clog2(ALLOC_DEPTH + 1);
   localparam int unsigned FLW = $clog2(FREE_DEPTH + 1);
   localparam int unsigned IW  = (ALW > FLW) ? ALW : FLW;
   localparam int unsigned SB  = ffba_pkg::SIZE_BITS;
   localparam int unsigned TB  = ffba_pkg::TAG_BITS;
   localparam int unsigned EB  = ffba_pkg::ENTRY_BITS;

   logic [EB-1:0] alloc_mem [ALLOC_DEPTH];
   logic [SB-1:0] free_mem  [FREE_DEPTH];

   logic [ALW-1:0] alen_ff;
   logic [FLW-1:0] flen_ff;
   logic [31:0]    total_ff;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  idx_nx;
   logic [1:0]     op_ff;
   logic [SB-1:0]  req_ff, req_in;
   logic [ffba_pkg::POS_BITS-1:0] pos_ff;
   logic [TB-1:0]  tag_ff;
   logic [SB-1:0]  f_rdata_ff;
   logic [EB-1:0]  a_rdata_ff;
   logic [2:0]     status_ff;
   logic [ffba_pkg::POS_BITS-1:0] fidx_ff;
   logic [SB-1:0]  rsize_ff;
   logic [TB-1:0]  rtag_ff;
   logic           rsp_valid_ff;
   ffba_pkg::rsp_item_type rsp_ff;
   logic [32:0]    sum;

   assign idx_nx = idx_ff + IW'(1);
   assign sum    = {1'b0, total_ff} + 33'(req_ff);

   always_comb begin
      req_in = req_data.request_size;
      if (req_data.request_size == '0) begin
         req_in = SB'(1);
      end else if (32'(req_data.request_size) > ffba_pkg::MAX_BLOCK) begin
         req_in = SB'(ffba_pkg::MAX_BLOCK);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_set_pos) begin
         idx_in = IW'(pos_ff);
      end else if (cmd.idx_inc) begin
         idx_in = idx_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.f_rd || cmd.f_rd_next) begin
         f_rdata_ff <= free_mem[cmd.f_rd_next ? idx_nx[FW-1:0] : idx_ff[FW-1:0]];
      end
      if (cmd.f_wr_shift) begin
         free_mem[idx_ff[FW-1:0]] <= f_rdata_ff;
      end else if (cmd.f_wr_split) begin
         free_mem[idx_ff[FW-1:0]] <= f_rdata_ff - req_ff;
      end else if (cmd.f_push) begin
         free_mem[flen_ff[FW-1:0]] <= rsize_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.a_rd || cmd.a_rd_next) begin
         a_rdata_ff <= alloc_mem[cmd.a_rd_next ? idx_nx[AW-1:0] : idx_ff[AW-1:0]];
      end
      if (cmd.a_wr_shift) begin
         alloc_mem[idx_ff[AW-1:0]] <= a_rdata_ff;
      end else if (cmd.a_push) begin
         alloc_mem[alen_ff[AW-1:0]] <= {req_ff, tag_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alen_ff      <= '0;
         flen_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.a_push) begin
            alen_ff <= alen_ff + ALW'(1);
         end else if (cmd.a_len_dec) begin
            alen_ff <= alen_ff - ALW'(1);
         end
         if (cmd.f_push) begin
            flen_ff <= flen_ff + FLW'(1);
         end else if (cmd.f_len_dec) begin
            flen_ff <= flen_ff - FLW'(1);
         end
         if (cmd.grow) begin
            total_ff <= sum[32] ? '1 : sum[31:0];
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         req_ff   <= req_in;
         pos_ff   <= req_data.position;
         tag_ff   <= req_data.tag;
         fidx_ff  <= '0;
         rsize_ff <= '0;
         rtag_ff  <= '0;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.fidx_set) begin
         fidx_ff <= ffba_pkg::POS_BITS'(idx_ff);
      end
      if (cmd.a_capture) begin
         rsize_ff <= a_rdata_ff[EB-1:TB];
         rtag_ff  <= a_rdata_ff[TB-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.status          <= status_ff;
         rsp_ff.free_index      <= fidx_ff;
         rsp_ff.released_size   <= rsize_ff;
         rsp_ff.released_tag    <= rtag_ff;
         rsp_ff.total_allocated <= total_ff;
         rsp_ff.allocated_count <= ffba_pkg::COUNT_BITS'(alen_ff);
         rsp_ff.free_count      <= ffba_pkg::COUNT_BITS'(flen_ff);
      end
   end

   assign stat.op       = op_ff;
   assign stat.a_full   = (32'(alen_ff) >= ALLOC_DEPTH);
   assign stat.f_full   = (32'(flen_ff) >= FREE_DEPTH);
   assign stat.pos_bad  = (32'(pos_ff) >= 32'(alen_ff));
   assign stat.scan_end = (32'(idx_ff) >= 32'(flen_ff));
   assign stat.f_last   = (32'(idx_nx) >= 32'(flen_ff));
   assign stat.a_last   = (32'(idx_nx) >= 32'(alen_ff));
   assign stat.fit      = (f_rdata_ff >= req_ff);
   assign stat.bigger   = (f_rdata_ff > req_ff);
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_alen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(alen_ff) <= ALLOC_DEPTH) else $error("allocated length beyond depth");
   a_flen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(flen_ff) <= FREE_DEPTH) else $error("free length beyond depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall)) else $error("result overwritten");
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff)) else $error("total decreased");
`endif

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator.
// One item at a time: place needs no walk; allocate walks the free list one entry
// at a time, and an exact fit then closes the gap by shifting each following entry;
// release closes the gap in the allocated list by shifting each following entry. The
// walks and shifts are sequential because each list memory has a single read and
// write port. The result waits in an output register, and the next item is taken
// while it waits.
module first_fit_block_allocator #(
   parameter int unsigned ALLOC_DEPTH = ffba_pkg::ALLOC_DEPTH_DEF,
   parameter int unsigned FREE_DEPTH  = ffba_pkg::FREE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffba_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffba_pkg::rsp_item_type rsp_data
);

   ffba_pkg::cmd_type  cmd;
   ffba_pkg::stat_type stat;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffba_dp #(
      .ALLOC_DEPTH (ALLOC_DEPTH),
      .FREE_DEPTH  (FREE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_first_fit_block_allocator.sv =====
// Testbench for the first-fit block allocator: predicted results checked against every item.
module tb_first_fit_block_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = 1024;
   localparam int IDLE_LIMIT = 20000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   ffba_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   ffba_pkg::rsp_item_type rsp_data;

   first_fit_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   logic [ffba_pkg::SIZE_BITS-1:0] used_size [LIST_DEPTH];
   logic [ffba_pkg::TAG_BITS-1:0]  used_tag  [LIST_DEPTH];
   logic [ffba_pkg::SIZE_BITS-1:0] spare_size[LIST_DEPTH];
   int                     used_len;
   int                     spare_len;
   logic [31:0]            grown_bytes;
   ffba_pkg::rsp_item_type pending_rsps[$];
   int                     mismatches = 0;
   int                     idle_cycles = 0;
   bit                     timed_out = 1'b0;
   int                     send_idle_pct;
   int                     stall_pct;
   bit                     hold_off_req = 1'b0;
   bit                     hold_off_taken = 1'b0;
   int                     hold_off_cycles = 0;

   function automatic ffba_pkg::rsp_item_type predict_alloc(ffba_pkg::req_item_type it);
      ffba_pkg::rsp_item_type r;
      logic [ffba_pkg::SIZE_BITS-1:0] sz;
      int hit;
      r = '0;
      r.status = ffba_pkg::ST_BAD_POS;
      sz = it.request_size;
      if (sz < 1) sz = 1;
      if (sz > ffba_pkg::MAX_BLOCK) sz = ffba_pkg::SIZE_BITS'(ffba_pkg::MAX_BLOCK);
      if (it.operation == ffba_pkg::OP_PLACE || it.operation == ffba_pkg::OP_ALLOC) begin
         if (used_len >= LIST_DEPTH) begin
            r.status = ffba_pkg::ST_FULL;
         end else begin
            hit = spare_len;
            if (it.operation == ffba_pkg::OP_ALLOC) begin
               for (int i = 0; i < spare_len; i++) begin
                  if (spare_size[i] >= sz) begin
                     hit = i;
                     break;
                  end
               end
            end
            if (hit >= spare_len) begin
               grown_bytes = (grown_bytes + sz < grown_bytes) ? 32'hFFFF_FFFF
                                                              : grown_bytes + sz;
               r.status = ffba_pkg::ST_GROWN;
            end else if (spare_size[hit] > sz) begin
               spare_size[hit] -= sz;
               r.free_index = ffba_pkg::POS_BITS'(hit);
               r.status = ffba_pkg::ST_SPLIT;
            end else begin
               sz = spare_size[hit];
               for (int i = hit; i + 1 < spare_len; i++) spare_size[i] = spare_size[i+1];
               spare_len--;
               r.free_index = ffba_pkg::POS_BITS'(hit);
               r.status = ffba_pkg::ST_EXACT;
            end
            used_size[used_len] = sz;
            used_tag[used_len] = it.tag;
            used_len++;
         end
      end else if (it.operation == ffba_pkg::OP_RELEASE) begin
         if (it.position >= used_len) begin
            r.status = ffba_pkg::ST_BAD_POS;
         end else if (spare_len >= LIST_DEPTH) begin
            r.status = ffba_pkg::ST_FULL;
         end else begin
            r.released_size = used_size[it.position];
            r.released_tag = used_tag[it.position];
            for (int i = it.position; i + 1 < used_len; i++) begin
               used_size[i] = used_size[i+1];
               used_tag[i] = used_tag[i+1];
            end
            used_len--;
            spare_size[spare_len] = r.released_size;
            spare_len++;
            r.status = ffba_pkg::ST_RELEASED;
         end
      end
      r.total_allocated = grown_bytes;
      r.allocated_count = ffba_pkg::COUNT_BITS'(used_len);
      r.free_count = ffba_pkg::COUNT_BITS'(spare_len);
      return r;
   endfunction

   task automatic send_item(ffba_pkg::req_item_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsps.push_back(predict_alloc(it));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic ffba_pkg::req_item_type make_item(logic [1:0] op, int sz, int pos,
                                                        int tg);
      ffba_pkg::req_item_type it;
      it.operation = op;
      it.request_size = ffba_pkg::SIZE_BITS'(sz);
      it.position = ffba_pkg::POS_BITS'(pos);
      it.tag = ffba_pkg::TAG_BITS'(tg);
      return it;
   endfunction

   function automatic ffba_pkg::req_item_type random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         return make_item(ffba_pkg::OP_PLACE, $urandom_range(127), $urandom_range(1023),
                          $urandom);
      if (pick < 65)
         return make_item(ffba_pkg::OP_ALLOC, $urandom_range(40), $urandom_range(1023),
                          $urandom);
      if (pick < 95)
         return make_item(ffba_pkg::OP_RELEASE, $urandom_range(127),
                          used_len > 0 ? $urandom_range(used_len - 1) : 0, $urandom);
      return make_item(2'($urandom_range(3)), $urandom_range(127), $urandom_range(1023),
                       $urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else if (rsp_data !== pending_rsps[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", pending_rsps[0], rsp_data);
            void'(pending_rsps.pop_front());
         end else begin
            void'(pending_rsps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_req && !hold_off_taken) begin
         hold_off_taken <= 1'b1;
         hold_off_cycles <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("first_fit_block_allocator test failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(make_item(ffba_pkg::OP_ALLOC, 10, 0, 16'h0001));
      send_item(make_item(ffba_pkg::OP_PLACE, 0, 1023, 16'hFFFF));
      send_item(make_item(ffba_pkg::OP_PLACE, 127, 0, 16'h0000));
      send_item(make_item(ffba_pkg::OP_PLACE, 124, 0, 16'hA5A5));
      send_item(make_item(ffba_pkg::OP_PLACE, 20, 0, 16'h5A5A));
      send_item(make_item(ffba_pkg::OP_RELEASE, 0, 1023, 16'h1234));
      send_item(make_item(ffba_pkg::OP_RELEASE, 0, 4, 0));
      send_item(make_item(2'd3, 127, 1023, 16'hFFFF));
      send_item(make_item(ffba_pkg::OP_RELEASE, 0, 3, 0));
      send_item(make_item(ffba_pkg::OP_RELEASE, 0, 0, 0));
      send_item(make_item(ffba_pkg::OP_RELEASE, 0, 0, 0));
      send_item(make_item(ffba_pkg::OP_ALLOC, 20, 0, 16'h0BAD));
      send_item(make_item(ffba_pkg::OP_ALLOC, 100, 0, 16'h0C0D));
      send_item(make_item(ffba_pkg::OP_ALLOC, 24, 0, 16'h0D0E));
      send_item(make_item(ffba_pkg::OP_ALLOC, 127, 0, 16'h0E0F));
      send_item(make_item(ffba_pkg::OP_ALLOC, 0, 0, 16'h0F00));
   endtask

   task automatic test_random(int count, int sidle, int rstall);
      send_idle_pct = sidle;
      stall_pct = rstall;
      repeat (count) send_item(random_item());
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_req <= 1'b1;
      repeat (30)
         send_item(make_item(ffba_pkg::OP_PLACE, $urandom_range(1, 124), 0, $urandom));
      wait_drained();
   endtask

   initial begin
      used_len = 0;
      spare_len = 0;
      grown_bytes = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random(135, 0, 0);
      test_random(135, 62, 0);
      test_backpressure();
      test_random(135, 0, 62);
      test_random(135, 26, 26);
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("first_fit_block_allocator test passed");
      else
         $display("first_fit_block_allocator test failed");
      $finish;
   end
endmodule
